/* design/rld_pkg.sv */
// Shared types, constants and helpers for the layer run-length decoder.
`timescale 1ns / 1ps

package rld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 28;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_PIXELS  = 2'd0,
    REG_HEIGHT_PIXELS = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PREFIX = 2'd1,
    ST_TRUNCATED  = 2'd2,
    ST_CAPACITY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } rld_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  pixel_value;
    logic [COUNT_W-1:0] run_length;
    logic [COUNT_W-1:0] run_start;
    logic [COUNT_W-1:0] nonzero_runs;
    logic [COUNT_W-1:0] pixels_written;
    status_t            status;
    logic               layer_done;
  } rld_result_t;

  // A nonzero 7-bit code maps to (code << 1) | 1; zero stays zero.
  function automatic logic [BYTE_W-1:0] widen_code(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-2:0] c;
    c = b[BYTE_W-2:0];
    return (c != '0) ? {c, 1'b1} : '0;
  endfunction

endpackage

/* design/rld_ifs.sv */
// Channel interfaces for the layer run-length decoder.
`timescale 1ns / 1ps

interface rld_in_if;
  import rld_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rld_out_if;
  import rld_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  pixel_value;
  logic [COUNT_W-1:0] run_length;
  logic [COUNT_W-1:0] run_start;
  logic [COUNT_W-1:0] nonzero_runs;
  logic [COUNT_W-1:0] pixels_written;
  logic [1:0]         status;
  logic               layer_done;
  modport source (output valid, output pixel_value, output run_length, output run_start,
                  output nonzero_runs, output pixels_written, output status,
                  output layer_done, input ready);
  modport sink   (input valid, input pixel_value, input run_length, input run_start,
                  input nonzero_runs, input pixels_written, input status,
                  input layer_done, output ready);
endinterface

interface rld_cfg_if;
  import rld_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* design/rld_in_reg.sv */
// Input register stage: captures one compressed byte per transaction.
`timescale 1ns / 1ps

module rld_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  rld_in_if.sink             in_bus,
  input  logic               advance,
  output logic               item_valid,
  output rld_pkg::rld_item_t item
);
  import rld_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  rld_item_t item_r;
  logic      take;

  assign in_bus.ready = !valid_r || advance;
  assign take         = in_bus.valid && in_bus.ready;
  assign valid_nxt    = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r.data_byte <= in_bus.data_byte;
      item_r.last_byte <= in_bus.last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* design/rld_decode.sv */
// Header parser and run bookkeeping: layer state and the result of each byte.
`timescale 1ns / 1ps

module rld_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  rld_pkg::rld_item_t            item,
  input  logic [rld_pkg::COUNT_W-1:0]   capacity,
  output logic                          emit,
  output rld_pkg::rld_result_t          res
);
  import rld_pkg::*;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN_FIRST,
    PH_LEN_MORE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  held_r, held_nxt;
  logic [COUNT_W-1:0] accum_r, accum_nxt;
  logic [1:0]         extra_r, extra_nxt;
  logic [COUNT_W-1:0] pos_r, pos_nxt;
  logic [COUNT_W-1:0] nz_r, nz_nxt;
  logic               skip_r, skip_nxt;

  logic [BYTE_W-1:0]  b;
  logic               last;
  logic               run_go;
  logic               err_go;
  logic [BYTE_W-1:0]  run_v;
  logic [COUNT_W-1:0] run_len;
  status_t            err_status;
  logic [BYTE_W-1:0]  err_v;
  logic [COUNT_W-1:0] acc_shift;
  logic [1:0]         extra_dec;
  logic [COUNT_W:0]   end_pos;
  logic [COUNT_W-1:0] nz_inc;
  logic               clear_go;
  logic               skip_go;

  assign b    = item.data_byte;
  assign last = item.last_byte;

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    accum_nxt  = accum_r;
    extra_nxt  = extra_r;
    pos_nxt    = pos_r;
    nz_nxt     = nz_r;
    skip_nxt   = skip_r;
    run_go     = 1'b0;
    err_go     = 1'b0;
    run_v      = held_r;
    run_len    = '0;
    err_status = ST_OK;
    err_v      = held_r;
    clear_go   = 1'b0;
    skip_go    = 1'b0;
    acc_shift  = {accum_r[COUNT_W-BYTE_W-1:0], b};
    extra_dec  = (extra_r != 2'd0) ? extra_r - 2'd1 : extra_r;

    if (skip_r) begin
      // Dropping bytes after an error until the layer's final byte.
      clear_go = last;
      skip_go  = 1'b0;
    end else begin
      unique case (phase_r)
        PH_CODE: begin
          if (!b[BYTE_W-1]) begin
            run_go  = 1'b1;
            run_v   = widen_code(b);
            run_len = COUNT_W'(1);
          end else begin
            held_nxt = widen_code(b);
            err_v    = widen_code(b);
            if (last) begin
              err_go     = 1'b1;
              err_status = ST_TRUNCATED;
            end else begin
              phase_nxt = PH_LEN_FIRST;
            end
          end
        end
        PH_LEN_FIRST: begin
          if (!b[BYTE_W-1]) begin
            run_go  = 1'b1;
            run_len = COUNT_W'(b);
          end else begin
            if (b[6] == 1'b0) begin
              accum_nxt = COUNT_W'(b[5:0]);
              extra_nxt = 2'd1;
            end else if (b[5] == 1'b0) begin
              accum_nxt = COUNT_W'(b[4:0]);
              extra_nxt = 2'd2;
            end else if (b[4] == 1'b0) begin
              accum_nxt = COUNT_W'(b[3:0]);
              extra_nxt = 2'd3;
            end else begin
              err_go     = 1'b1;
              err_status = ST_BAD_PREFIX;
            end
            if (!err_go) begin
              if (last) begin
                err_go     = 1'b1;
                err_status = ST_TRUNCATED;
              end else begin
                phase_nxt = PH_LEN_MORE;
              end
            end
          end
        end
        PH_LEN_MORE: begin
          accum_nxt = acc_shift;
          extra_nxt = extra_dec;
          if (extra_dec == 2'd0) begin
            run_go  = 1'b1;
            run_len = acc_shift;
          end else if (last) begin
            err_go     = 1'b1;
            err_status = ST_TRUNCATED;
          end
        end
        default: begin
          phase_nxt = PH_CODE;
        end
      endcase
    end

    end_pos = {1'b0, pos_r} + {1'b0, run_len};
    nz_inc  = nz_r + COUNT_W'(run_v != '0);

    res.pixel_value    = err_v;
    res.run_length     = '0;
    res.run_start      = pos_r;
    res.nonzero_runs   = nz_r;
    res.pixels_written = pos_r;
    res.status         = err_status;
    res.layer_done     = 1'b1;
    emit               = run_go || err_go;

    if (run_go) begin
      res.pixel_value = run_v;
      res.run_length  = run_len;
      if (end_pos > {1'b0, capacity}) begin
        res.status = ST_CAPACITY;
        clear_go   = 1'b1;
        skip_go    = !last;
      end else begin
        res.status         = ST_OK;
        res.nonzero_runs   = nz_inc;
        res.pixels_written = end_pos[COUNT_W-1:0];
        res.layer_done     = last;
        nz_nxt             = nz_inc;
        pos_nxt            = end_pos[COUNT_W-1:0];
        phase_nxt          = PH_CODE;
        accum_nxt          = '0;
        extra_nxt          = 2'd0;
        clear_go           = last;
        skip_go            = 1'b0;
      end
    end else if (err_go) begin
      clear_go = 1'b1;
      skip_go  = !last;
    end

    if (clear_go) begin
      phase_nxt = PH_CODE;
      held_nxt  = '0;
      accum_nxt = '0;
      extra_nxt = 2'd0;
      pos_nxt   = '0;
      nz_nxt    = '0;
      skip_nxt  = skip_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      held_r  <= '0;
      accum_r <= '0;
      extra_r <= 2'd0;
      pos_r   <= '0;
      nz_r    <= '0;
      skip_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      accum_r <= accum_nxt;
      extra_r <= extra_nxt;
      pos_r   <= pos_nxt;
      nz_r    <= nz_nxt;
      skip_r  <= skip_nxt;
    end
  end

`ifndef SYNTHESIS
  // An error before the final byte must put the decoder into drop mode.
  a_err_sets_skip: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && (res.status != ST_OK) && !last |=> skip_r)
    else $error("error result did not start dropping bytes");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> !emit)
    else $error("result produced while dropping bytes");

  a_more_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEN_MORE) |-> (extra_r != 2'd0))
    else $error("waiting for length bytes with none outstanding");

  // A finished layer leaves the position counter cleared.
  a_done_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && res.layer_done |=> (pos_r == '0) && (nz_r == '0))
    else $error("layer state not cleared at end of layer");
`endif

endmodule

/* design/rld_out_reg.sv */
// Result register: holds one finished run until the sink takes it.
`timescale 1ns / 1ps

module rld_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rld_pkg::rld_result_t res,
  output logic                 slot_free,
  rld_out_if.source            out_bus
);
  import rld_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  rld_result_t res_r;

  assign slot_free = !valid_r || out_bus.ready;
  assign valid_nxt = load ? 1'b1 : (out_bus.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid          = valid_r;
  assign out_bus.pixel_value    = res_r.pixel_value;
  assign out_bus.run_length     = res_r.run_length;
  assign out_bus.run_start      = res_r.run_start;
  assign out_bus.nonzero_runs   = res_r.nonzero_runs;
  assign out_bus.pixels_written = res_r.pixels_written;
  assign out_bus.status         = res_r.status;
  assign out_bus.layer_done     = res_r.layer_done;

`ifndef SYNTHESIS
  a_ok_adds_up: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (res_r.status == ST_OK) |->
      (res_r.pixels_written == res_r.run_start + res_r.run_length))
    else $error("pixel total does not match run start plus length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("result register loaded while still full");

  // A stalled result stays on the bus unchanged.
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_bus.ready |=> valid_r && $stable(res_r))
    else $error("result changed while the sink was stalled");
`endif

endmodule

/* design/layer_run_length_decoder.sv */
// Top level of the layer run-length decoder.
//
//   channel  | direction | transaction
//   in_bus   | sink      | one compressed byte and its last-byte flag
//   out_bus  | source    | one finished run with totals and status
//   cfg_bus  | sink      | write of width_pixels or height_pixels
//
// One byte is accepted per cycle unless out_bus stalls; each result is registered.
// The rate is set by the per-byte layer state update: a 29-bit position add
// and compare against the capacity in the decode stage.
// Synchronous reset clears the layer state and sets both dimensions to 1.
// With out_bus stalled the result is held, one more byte is buffered, and
// then in_bus ready drops. Configuration writes are always ready.
`timescale 1ns / 1ps

module layer_run_length_decoder (
  input  logic       clk,
  input  logic       rst_n,
  rld_in_if.sink     in_bus,
  rld_out_if.source  out_bus,
  rld_cfg_if.sink    cfg_bus
);
  import rld_pkg::*;

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [COUNT_W-1:0] cap_r;
  logic               cfg_take;

  logic        item_valid;
  rld_item_t   item;
  logic        slot_free;
  logic        fire;
  logic        emit;
  rld_result_t res;

  assign cfg_bus.ready = 1'b1;
  assign cfg_take      = cfg_bus.valid && cfg_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      cap_r    <= COUNT_W'(1);
    end else begin
      if (cfg_take) begin
        case (cfg_bus.reg_index)
          REG_WIDTH_PIXELS:  width_r  <= cfg_bus.wdata[DIM_W-1:0];
          REG_HEIGHT_PIXELS: height_r <= cfg_bus.wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      // Capacity is registered from the dimensions and follows them in the next cycle.
      cap_r <= COUNT_W'(width_r) * COUNT_W'(height_r);
    end
  end

  assign fire = item_valid && slot_free;

  rld_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  rld_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item),
    .capacity (cap_r),
    .emit     (emit),
    .res      (res)
  );

  rld_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .res       (res),
    .slot_free (slot_free),
    .out_bus   (out_bus)
  );

endmodule
